>>> sv/distance_vector_route_table_assert.svh
// Assertion macros of the route table checker
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH

// Same-cycle implication, clocked on clk, idle during reset
`define DVRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dvrt assertion failed");

// Next-cycle implication, clocked on clk, idle during reset
`define DVRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dvrt assertion failed");

`endif

>>> sv/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared sizes, codes and structs of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int MAX_REMOVALS = 64;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(MAX_REMOVALS + 1);

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_ADV    = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_SWEEP  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    STS_DONE   = 3'd0,
    STS_REJECT = 3'd1,
    STS_MISS   = 3'd2,
    STS_FULL   = 3'd3,
    STS_SELF   = 3'd4
  } status_t;

  localparam logic [1:0] KIND_SELF    = 2'd0;
  localparam logic [1:0] KIND_LEARNED = 2'd2;

  // Configuration register indexes
  localparam logic CFG_AGING   = 1'b0;
  localparam logic CFG_CEILING = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Command broadcast to every cell during a pass
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] seconds_now;
    logic [15:0] aging_limit;
    logic [7:0]  metric_ceiling;
  } req_t;

  // Word handed from cell to cell along the chain
  typedef struct packed {
    logic             active;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic [7:0]       found_metric;
    logic [31:0]      found_link;
    logic [1:0]       found_kind;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [CNT_W-1:0] removed;
  } chain_t;

  // Entry write and delete broadcast at the end of a pass
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [63:0]      key_hi;
    logic [63:0]      key_lo;
    logic [7:0]       metric;
    logic [31:0]      link;
    logic [1:0]       kind;
    logic [31:0]      stamp;
    logic             del_en;
    logic [IDX_W-1:0] del_idx;
  } wr_t;

endpackage

>>> sv/dvrt_cell.sv
// ----------------------------------------------------------------------------
// dvrt_cell
// One table entry: matches the key, reports itself free, ages itself out,
// and hands the accumulated pass word to the next cell.
// ----------------------------------------------------------------------------
module dvrt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [dvrt_pkg::IDX_W-1:0] idx,
  input  dvrt_pkg::req_t            req,
  input  dvrt_pkg::wr_t             wr,
  input  dvrt_pkg::chain_t          chain_in,
  output dvrt_pkg::chain_t          chain_out
);
  import dvrt_pkg::*;

  logic        valid_r, valid_nxt;
  logic [63:0] key_hi_r, key_lo_r;
  logic [7:0]  metric_r;
  logic [31:0] link_r;
  logic [1:0]  kind_r;
  logic [31:0] stamp_r;
  chain_t      out_r, out_nxt;
  logic        match;
  logic        stale;
  logic [31:0] age;

  // Evaluate this entry against the passing word
  always_comb begin
    match     = valid_r && (key_hi_r == req.key_hi) && (key_lo_r == req.key_lo);
    age       = req.seconds_now - stamp_r;
    stale     = valid_r && (kind_r == KIND_LEARNED) && (metric_r != 8'd0) &&
                ((age >= {16'd0, req.aging_limit}) || (metric_r > req.metric_ceiling));
    out_nxt   = chain_in;
    valid_nxt = valid_r;
    if (chain_in.active) begin
      if (req.cmd == CMD_SWEEP) begin
        if (stale && (chain_in.removed < CNT_W'(MAX_REMOVALS))) begin
          valid_nxt       = 1'b0;
          out_nxt.removed = CNT_W'(chain_in.removed + 1'b1);
        end
      end else begin
        if (match && !chain_in.found) begin
          out_nxt.found        = 1'b1;
          out_nxt.found_idx    = idx;
          out_nxt.found_metric = metric_r;
          out_nxt.found_link   = link_r;
          out_nxt.found_kind   = kind_r;
        end
        if (!valid_r && !chain_in.free_found) begin
          out_nxt.free_found = 1'b1;
          out_nxt.free_idx   = idx;
        end
      end
    end
    if (wr.wr_en && (wr.wr_idx == idx)) begin
      valid_nxt = 1'b1;
    end
    if (wr.del_en && (wr.del_idx == idx)) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      out_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      out_r   <= out_nxt;
    end
  end

  // Store entry payload
  always_ff @(posedge clk) begin
    if (wr.wr_en && (wr.wr_idx == idx)) begin
      key_hi_r <= wr.key_hi;
      key_lo_r <= wr.key_lo;
      metric_r <= wr.metric;
      link_r   <= wr.link;
      kind_r   <= wr.kind;
      stamp_r  <= wr.stamp;
    end
  end

  assign chain_out = out_r;

endmodule

>>> sv/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Route table of 128-bit keys built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Each word is one command. Add, advertised route, lookup, delete and sweep
// send a pass word down the chain of TABLE_DEPTH cells, one cell per cycle,
// starting the cycle after acceptance; a tick or an unused command skips the
// chain. One command is in flight at a time; the next word is accepted the
// cycle after the result is loaded. A finished result waits in the output
// register while the next word is accepted.
// Configuration writes take effect at once.
module distance_vector_route_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_addr_high,
  input  logic [63:0] in_addr_low,
  input  logic [7:0]  in_route_metric,
  input  logic [31:0] in_link_id,
  input  logic [1:0]  in_entry_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_hit_metric,
  output logic [31:0] out_hit_link,
  output logic [6:0]  out_removed_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import dvrt_pkg::*;

  state_t      state_r, state_nxt;
  logic [2:0]  cmd_r;
  logic [63:0] hi_r, lo_r;
  logic [7:0]  metric_r;
  logic [31:0] link_r;
  logic [1:0]  mode_r;
  logic [31:0] seconds_r;
  logic [15:0] limit_r;
  logic [7:0]  ceiling_r;
  logic        start_r;

  logic [2:0]  res_status_r, res_status_nxt;
  logic [7:0]  res_metric_r, res_metric_nxt;
  logic [31:0] res_link_r, res_link_nxt;
  logic [6:0]  res_removed_r, res_removed_nxt;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [7:0]  out_metric_r;
  logic [31:0] out_link_r;
  logic [6:0]  out_removed_r;

  logic        accept;
  logic        start;
  logic        load_out;
  logic        scan_cmd;
  logic [7:0]  m_inc;
  req_t        req;
  wr_t         wr;
  chain_t      head;
  chain_t      chain_w [TABLE_DEPTH+1];
  chain_t      tail;

  assign accept   = in_valid && in_ready;
  assign scan_cmd = (in_cmd == CMD_ADD) || (in_cmd == CMD_ADV) || (in_cmd == CMD_LOOKUP) ||
                    (in_cmd == CMD_DELETE) || (in_cmd == CMD_SWEEP);
  assign tail     = chain_w[TABLE_DEPTH];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = scan_cmd ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (tail.active) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: in_ready = 1'b0;
      ST_DONE: load_out = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign start = accept && scan_cmd;

  // Broadcast the latched command word and the head of chain, driven from the registered start flag
  always_comb begin
    req.cmd            = cmd_r;
    req.key_hi         = hi_r;
    req.key_lo         = lo_r;
    req.seconds_now    = seconds_r;
    req.aging_limit    = limit_r;
    req.metric_ceiling = ceiling_r;
    head               = '0;
    head.active        = start_r;
  end

  assign chain_w[0] = head;

  // Clear the result on acceptance and decide the outcome when the pass word leaves the chain
  always_comb begin
    m_inc           = (metric_r == 8'hFF) ? 8'hFF : metric_r + 8'd1;
    res_status_nxt  = res_status_r;
    res_metric_nxt  = res_metric_r;
    res_link_nxt    = res_link_r;
    res_removed_nxt = res_removed_r;
    wr              = '0;
    wr.key_hi       = hi_r;
    wr.key_lo       = lo_r;
    wr.link         = link_r;
    wr.stamp        = seconds_r;
    if (accept) begin
      res_status_nxt  = STS_DONE;
      res_metric_nxt  = 8'd0;
      res_link_nxt    = 32'd0;
      res_removed_nxt = 7'd0;
    end
    if (tail.active) begin
      case (cmd_r)
        CMD_ADD: begin
          if (tail.found) begin
            res_status_nxt = STS_REJECT;
          end else if (tail.free_found) begin
            wr.wr_en  = 1'b1;
            wr.wr_idx = tail.free_idx;
            wr.metric = metric_r;
            wr.kind   = mode_r;
          end else begin
            res_status_nxt = STS_FULL;
          end
        end
        CMD_ADV: begin
          wr.metric = m_inc;
          wr.kind   = KIND_LEARNED;
          if (tail.found) begin
            if (tail.found_kind == KIND_SELF) begin
              res_status_nxt = STS_SELF;
            end else if ((m_inc < tail.found_metric) ||
                         ((m_inc == tail.found_metric) && (link_r == tail.found_link))) begin
              wr.wr_en  = 1'b1;
              wr.wr_idx = tail.found_idx;
            end else begin
              res_status_nxt = STS_REJECT;
            end
          end else if (tail.free_found) begin
            wr.wr_en  = 1'b1;
            wr.wr_idx = tail.free_idx;
          end else begin
            res_status_nxt = STS_FULL;
          end
        end
        CMD_LOOKUP: begin
          if (tail.found) begin
            res_metric_nxt = tail.found_metric;
            res_link_nxt   = tail.found_link;
          end else begin
            res_status_nxt = STS_MISS;
          end
        end
        CMD_DELETE: begin
          if (tail.found) begin
            wr.del_en  = 1'b1;
            wr.del_idx = tail.found_idx;
          end else begin
            res_status_nxt = STS_MISS;
          end
        end
        CMD_SWEEP: res_removed_nxt = 7'(tail.removed);
        default:   res_status_nxt  = STS_DONE;
      endcase
    end
  end

  // Chain of entry cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dvrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (IDX_W'(g)),
      .req       (req),
      .wr        (wr),
      .chain_in  (chain_w[g]),
      .chain_out (chain_w[g+1])
    );
  end

  // Hold control state, seconds counter and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seconds_r   <= 32'd0;
      limit_r     <= 16'd30;
      ceiling_r   <= 8'd16;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start;
      if (accept && (in_cmd == CMD_TICK)) begin
        seconds_r <= seconds_r + 32'd1;
      end
      if (cfg_we && (cfg_index == CFG_AGING)) begin
        limit_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_CEILING)) begin
        ceiling_r <= cfg_data[7:0];
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch command word, result and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      hi_r     <= in_addr_high;
      lo_r     <= in_addr_low;
      metric_r <= in_route_metric;
      link_r   <= in_link_id;
      mode_r   <= in_entry_mode;
    end
    res_status_r  <= res_status_nxt;
    res_metric_r  <= res_metric_nxt;
    res_link_r    <= res_link_nxt;
    res_removed_r <= res_removed_nxt;
    if (load_out) begin
      out_status_r  <= res_status_r;
      out_metric_r  <= res_metric_r;
      out_link_r    <= res_link_r;
      out_removed_r <= res_removed_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_hit_metric    = out_metric_r;
  assign out_hit_link      = out_link_r;
  assign out_removed_count = out_removed_r;

endmodule

>>> sv/dvrt_checker.sv
// ----------------------------------------------------------------------------
// dvrt_checker
// Port-level checks of the route table, bound to the top level.
// ----------------------------------------------------------------------------
`include "distance_vector_route_table_assert.svh"

module dvrt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [7:0]  out_hit_metric,
  input logic [31:0] out_hit_link,
  input logic [6:0]  out_removed_count
);
  import dvrt_pkg::*;

  // Stalled result word stays valid and keeps its status
  `DVRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))
  // One command in flight: no accept right after an accept
  `DVRT_ASSERT_NEXT(a_one_cmd, in_valid && in_ready, !in_ready)
  // Status is a defined code
  `DVRT_ASSERT_NOW(a_status_code, out_valid, out_status <= STS_SELF)
  // A failing command carries no hit and no removal count
  `DVRT_ASSERT_NOW(a_fail_clean, out_valid && (out_status != STS_DONE),
    (out_hit_metric == 8'd0) && (out_hit_link == 32'd0) && (out_removed_count == 7'd0))

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);
